@@ rtl/ntm_pkg.sv @@
// Shared constants and types for the nearest triangle match unit.
package ntm_pkg;

	localparam int STORE_DEPTH_DEF = 256;
	localparam int COORD_BITS_DEF  = 16;

	localparam int IDX_OUT_W  = 8;
	localparam int COST_OUT_W = 36;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// Control tag that travels with each stored entry down the cell chain.
	typedef struct packed {
		logic vld;
		logic last;
	} ntm_tag_t;

endpackage

@@ rtl/ntm_cell.sv @@
// One rotation cell: cost of one vertex rotation, merged into the running minimum.
module ntm_cell import ntm_pkg::*; #(
	parameter int CB    = COORD_BITS_DEF,
	parameter int IDX_W = 8,
	parameter int ROT   = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [9*CB-1:0]       qry,
	input  logic [9*CB-1:0]       ent_in,
	input  ntm_tag_t              tag_in,
	input  logic [IDX_W-1:0]      idx_in,
	input  logic [2*CB+3:0]       min_in,
	output logic [9*CB-1:0]       ent_s1,
	output ntm_tag_t              tag_s1,
	output logic [IDX_W-1:0]      idx_s1,
	output logic [2*CB+3:0]       min_out,
	output ntm_tag_t              tag_out,
	output logic [IDX_W-1:0]      idx_out
);

	localparam int SQ_W = 2 * CB;
	localparam int VS_W = 2 * CB + 2;
	localparam int SW   = 2 * CB + 4;

	logic [SQ_W-1:0]        sq_s1 [9];
	logic signed [2*CB+1:0] prod [9];
	logic [VS_W-1:0]        vs_s2 [3];
	ntm_tag_t               tag_s2;
	logic [IDX_W-1:0]       idx_s2;
	logic [SW-1:0]          cost;

	// Each coordinate difference is squared in its own multiplier.
	for (genvar j = 0; j < 9; j++) begin : g_sq
		localparam int QV = ((j / 3) + ROT) % 3;
		localparam int QJ = QV * 3 + (j % 3);
		logic signed [CB:0] diff;
		assign diff = $signed({qry[QJ*CB+CB-1], qry[QJ*CB +: CB]})
			- $signed({ent_in[j*CB+CB-1], ent_in[j*CB +: CB]});
		assign prod[j] = diff * diff;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 9; j++) begin
			sq_s1[j] <= prod[j][SQ_W-1:0];
		end
		ent_s1 <= ent_in;
		idx_s1 <= idx_in;
		idx_s2 <= idx_s1;
		idx_out <= idx_s2;
		for (int v = 0; v < 3; v++) begin
			vs_s2[v] <= VS_W'(sq_s1[3*v]) + VS_W'(sq_s1[3*v+1]) + VS_W'(sq_s1[3*v+2]);
		end
		min_out <= (cost < min_in) ? cost : min_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			tag_s2  <= '0;
			tag_out <= '0;
		end else begin
			tag_s1  <= tag_in;
			tag_s2  <= tag_s1;
			tag_out <= tag_s2;
		end
	end

	assign cost = SW'(vs_s2[0]) + SW'(vs_s2[1]) + SW'(vs_s2[2]);

endmodule

@@ rtl/ntm_best.sv @@
// Running argmin over the per-entry costs that leave the cell chain.
module ntm_best import ntm_pkg::*; #(
	parameter int SW    = 36,
	parameter int IDX_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ntm_tag_t         tag,
	input  logic [IDX_W-1:0] idx,
	input  logic [SW-1:0]    cost,
	output logic             done,
	output logic [SW-1:0]    res_cost,
	output logic [IDX_W-1:0] res_idx
);

	logic             have_q;
	logic [SW-1:0]    best_q;
	logic [IDX_W-1:0] bidx_q;
	logic             take;
	logic [SW-1:0]    nxt_cost;
	logic [IDX_W-1:0] nxt_idx;

	// Strict compare keeps the first index on ties.
	assign take     = !have_q || (cost < best_q);
	assign nxt_cost = take ? cost : best_q;
	assign nxt_idx  = take ? idx : bidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= tag.vld && tag.last;
			if (tag.vld) begin
				have_q <= !tag.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tag.vld) begin
			best_q   <= nxt_cost;
			bidx_q   <= nxt_idx;
			res_cost <= nxt_cost;
			res_idx  <= nxt_idx;
		end
	end

endmodule

@@ rtl/nearest_triangle_match_unit.sv @@
// Top level of the nearest triangle match unit: triangle store, scan control and cell chain.
//
// The unit keeps up to STORE_DEPTH triangles in an on-chip memory and answers one
// transaction at a time. A clear, an append, an ignored opcode and a query on an empty
// store each finish without a scan and put their result in the output register at once.
// A query on N stored triangles reads the memory one entry per cycle, so it occupies
// the unit for the scan of N entries plus the pipeline drain (memory read, three
// rotation cells each one stage behind the previous, and the argmin register); the
// single memory read port sets the scan rate. Each stored entry flows through a
// chain of three identical cells, one per cyclic rotation of the query vertices, and
// each cell hands the entry and the running minimum cost to its neighbor. The store
// needs no clearing pass: only entries below the fill count are ever read. Costs are
// unsigned Q20.16 sums of nine squared Q8.8 differences, each square kept to its low
// 2*COORD_BITS bits; ties report the first index. A new transaction is accepted as soon
// as the unit is idle and the output register is empty or being emptied in the same cycle.
module nearest_triangle_match_unit import ntm_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	input  logic signed [COORD_BITS-1:0] c_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [IDX_OUT_W-1:0]         match_index,
	output logic                         found,
	output logic [COST_OUT_W-1:0]        best_cost,
	output logic                         store_full
);

	localparam int CB    = COORD_BITS;
	localparam int ENT_W = 9 * CB;
	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int SW    = 2 * CB + 4;
	localparam int EXT_W = (SW > COST_OUT_W) ? SW : COST_OUT_W;
	localparam int IX_W  = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] scan_addr_q;
	logic [ENT_W-1:0] qry_q;
	logic [ENT_W-1:0] mem [STORE_DEPTH];
	logic [ENT_W-1:0] rd_ent_q;
	ntm_tag_t         rd_tag_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             accept;
	logic             is_full;
	logic             scan_last;
	logic             out_load;
	logic [ENT_W-1:0] in_ent;

	logic [ENT_W-1:0] c_ent [4];
	ntm_tag_t         c_tag [4];
	logic [IDX_W-1:0] c_idx [4];
	logic [SW-1:0]    c_min [4];
	ntm_tag_t         m_tag [3];
	logic [IDX_W-1:0] m_idx [3];

	logic             best_done;
	logic [SW-1:0]    best_res;
	logic [IDX_W-1:0] best_idx;
	logic [EXT_W-1:0] cost_ext;
	logic [IX_W-1:0]  idx_ext;

	assign in_ent = {c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x};
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid || out_ready);
	assign accept    = in_valid && in_ready;
	assign is_full   = (count_q == CNT_W'(STORE_DEPTH));
	assign scan_last = ((CNT_W'(scan_addr_q) + CNT_W'(1)) == count_q);

	// A result enters the output register either straight from an idle transaction
	// that needs no scan, or at the end of the drain.
	assign out_load = ((state_q == ST_IDLE) && accept
			&& !((opcode == OP_QUERY) && (count_q != '0)))
		|| ((state_q == ST_DRAIN) && best_done);

	// The store has no reset; entries at or above the fill count are never read.
	always_ff @(posedge clk) begin
		if (accept && (opcode == OP_APPEND) && !is_full) begin
			mem[count_q[IDX_W-1:0]] <= in_ent;
		end
		rd_ent_q <= mem[scan_addr_q];
		rd_idx_q <= scan_addr_q;
		if (accept) begin
			qry_q <= in_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_tag_q <= '0;
		end else begin
			rd_tag_q.vld  <= (state_q == ST_SCAN);
			rd_tag_q.last <= (state_q == ST_SCAN) && scan_last;
		end
	end

	// The chain: each cell takes the entry from its neighbor's first stage and the
	// running minimum from its neighbor's last stage.
	assign c_ent[0] = rd_ent_q;
	assign c_tag[0] = rd_tag_q;
	assign c_idx[0] = rd_idx_q;
	assign c_min[0] = '1;

	for (genvar r = 0; r < 3; r++) begin : g_cell
		ntm_cell #(
			.CB   (CB),
			.IDX_W(IDX_W),
			.ROT  (r)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.qry    (qry_q),
			.ent_in (c_ent[r]),
			.tag_in (c_tag[r]),
			.idx_in (c_idx[r]),
			.min_in (c_min[r]),
			.ent_s1 (c_ent[r+1]),
			.tag_s1 (c_tag[r+1]),
			.idx_s1 (c_idx[r+1]),
			.min_out(c_min[r+1]),
			.tag_out(m_tag[r]),
			.idx_out(m_idx[r])
		);
	end

	ntm_best #(
		.SW   (SW),
		.IDX_W(IDX_W)
	) u_best (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag     (m_tag[2]),
		.idx     (m_idx[2]),
		.cost    (c_min[3]),
		.done    (best_done),
		.res_cost(best_res),
		.res_idx (best_idx)
	);

	assign cost_ext = EXT_W'(best_res);
	assign idx_ext  = IX_W'(best_idx);

	// Control and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_addr_q <= '0;
			out_valid   <= 1'b0;
			match_index <= '0;
			found       <= 1'b0;
			best_cost   <= '0;
			store_full  <= 1'b0;
		end else begin
			out_valid <= out_load || (out_valid && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if ((opcode == OP_QUERY) && (count_q != '0)) begin
							state_q     <= ST_SCAN;
							scan_addr_q <= '0;
						end else begin
							match_index <= '0;
							found       <= 1'b0;
							best_cost   <= '0;
							store_full  <= (opcode == OP_APPEND) && is_full;
							if (opcode == OP_CLEAR) begin
								count_q <= '0;
							end else if ((opcode == OP_APPEND) && !is_full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_addr_q <= scan_addr_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (best_done) begin
						state_q     <= ST_IDLE;
						found       <= 1'b1;
						store_full  <= 1'b0;
						match_index <= idx_ext[IDX_OUT_W-1:0];
						if ((cost_ext >> COST_OUT_W) != '0) begin
							best_cost <= '1;
						end else begin
							best_cost <= cost_ext[COST_OUT_W-1:0];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STORE_DEPTH))
		else $error("fill count exceeds store depth");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		best_done |-> (state_q == ST_DRAIN))
		else $error("argmin result outside of drain");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("transaction accepted during a scan");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && scan_last) |=> (state_q == ST_DRAIN))
		else $error("scan did not hand over to drain");
`endif

endmodule
